FILE: rtl/snt_pkg.sv
// Shared constants and controller/datapath interface types for the sphenic number test.
package snt_pkg;

    // Default width of the classified integer
    localparam int DEFAULT_VALUE_WIDTH = 16;
    // Number of distinct prime factors a sphenic number has
    localparam int PRIME_TARGET        = 3;
    // First trial divisor
    localparam int FIRST_CANDIDATE     = 2;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV_A,
        S_TEST_A,
        S_START_B,
        S_DIV_B,
        S_TEST_B,
        S_DONE
    } t_state;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;
        logic div_start;
        logic take_quot;
        logic count_prime;
        logic next_cand;
        logic fail;
        logic emit;
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic cand_ok;
        logic div_done;
        logic rem_zero;
        logic primes_full;
    } t_status;

endpackage

FILE: rtl/snt_div.sv
// Restoring divider, one quotient bit per cycle.
module snt_div #(
    parameter int VALUE_WIDTH = snt_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_dividend,
    input  logic [VALUE_WIDTH-1:0] i_divisor,
    output logic                   o_done,
    output logic [VALUE_WIDTH-1:0] o_quot,
    output logic [VALUE_WIDTH-1:0] o_rem
);
    localparam int CW = $clog2(VALUE_WIDTH);

    logic                   r_run;
    logic                   r_done;
    logic [CW-1:0]          r_cnt;
    logic [VALUE_WIDTH-1:0] r_dvd;
    logic [VALUE_WIDTH-1:0] r_dvs;
    logic [VALUE_WIDTH-1:0] r_rem;

    logic [VALUE_WIDTH:0]   rem_sh;
    logic [VALUE_WIDTH:0]   diff;
    logic                   ge;

    // Shift in next dividend bit and trial-subtract
    always_comb begin
        rem_sh = {r_rem, r_dvd[VALUE_WIDTH-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        ge     = (rem_sh >= {1'b0, r_dvs});
    end

    // Control: run flag, step count, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(VALUE_WIDTH - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend register turns into the quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_run) begin
            r_rem <= ge ? diff[VALUE_WIDTH-1:0] : rem_sh[VALUE_WIDTH-1:0];
            r_dvd <= {r_dvd[VALUE_WIDTH-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/snt_dpath.sv
// Datapath: remaining cofactor, candidate and its square, prime count, result register.
module snt_dpath #(
    parameter int VALUE_WIDTH = snt_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  snt_pkg::t_cmd          i_cmd,
    output snt_pkg::t_status       o_status,
    output logic                   o_valid,
    output logic                   o_is_sphenic
);
    localparam int W = VALUE_WIDTH;

    logic [W-1:0] r_rest;
    logic [W-1:0] r_cand;
    logic [W:0]   r_cand_sq;
    logic [1:0]   r_primes;
    logic         r_fail;
    logic         r_valid;
    logic         r_is_sphenic;

    logic         div_done;
    logic [W-1:0] quot;
    logic [W-1:0] rem;
    logic         rest_gt1;
    logic         final_ok;

    snt_div #(.VALUE_WIDTH(W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_rest),
        .i_divisor  (r_cand),
        .o_done     (div_done),
        .o_quot     (quot),
        .o_rem      (rem)
    );

    // Final verdict: leftover cofactor above one is one more prime
    always_comb begin
        rest_gt1 = (r_rest > W'(1));
        final_ok = !r_fail &&
                   (((r_primes == 2'(snt_pkg::PRIME_TARGET)) && !rest_gt1) ||
                    ((r_primes == 2'(snt_pkg::PRIME_TARGET - 1)) && rest_gt1));
    end

    // Status back to the controller
    always_comb begin
        o_status.cand_ok     = (r_cand_sq <= {1'b0, r_rest});
        o_status.div_done    = div_done;
        o_status.rem_zero    = (rem == '0);
        o_status.primes_full = (r_primes == 2'(snt_pkg::PRIME_TARGET));
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rest    <= i_value;
            r_cand    <= W'(snt_pkg::FIRST_CANDIDATE);
            r_cand_sq <= (W+1)'(snt_pkg::FIRST_CANDIDATE * snt_pkg::FIRST_CANDIDATE);
        end else begin
            if (i_cmd.take_quot) begin
                r_rest <= quot;
            end
            // (d+1)^2 = d^2 + 2d + 1
            if (i_cmd.next_cand) begin
                r_cand    <= r_cand + W'(1);
                r_cand_sq <= r_cand_sq + {r_cand, 1'b1};
            end
        end
    end

    // Prime count and failure flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primes <= '0;
            r_fail   <= 1'b0;
        end else if (i_cmd.load) begin
            r_primes <= '0;
            r_fail   <= 1'b0;
        end else begin
            if (i_cmd.count_prime) begin
                r_primes <= r_primes + 2'd1;
            end
            if (i_cmd.fail) begin
                r_fail <= 1'b1;
            end
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_is_sphenic <= final_ok;
        end
    end

    assign o_valid      = r_valid;
    assign o_is_sphenic = r_is_sphenic;

endmodule

FILE: rtl/snt_ctrl.sv
// Controller state machine sequencing trial division over candidates.
module snt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  snt_pkg::t_status i_status,
    output snt_pkg::t_cmd    o_cmd,
    output logic             o_busy
);
    snt_pkg::t_state r_state;
    snt_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= snt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            snt_pkg::S_IDLE: begin
                if (i_start) n_state = snt_pkg::S_CHECK;
            end
            snt_pkg::S_CHECK: begin
                n_state = i_status.cand_ok ? snt_pkg::S_DIV_A : snt_pkg::S_DONE;
            end
            snt_pkg::S_DIV_A: begin
                if (i_status.div_done) n_state = snt_pkg::S_TEST_A;
            end
            snt_pkg::S_TEST_A: begin
                n_state = i_status.rem_zero ? snt_pkg::S_START_B : snt_pkg::S_CHECK;
            end
            snt_pkg::S_START_B: begin
                n_state = snt_pkg::S_DIV_B;
            end
            snt_pkg::S_DIV_B: begin
                if (i_status.div_done) n_state = snt_pkg::S_TEST_B;
            end
            snt_pkg::S_TEST_B: begin
                if (i_status.rem_zero || i_status.primes_full) begin
                    n_state = snt_pkg::S_DONE;
                end else begin
                    n_state = snt_pkg::S_CHECK;
                end
            end
            snt_pkg::S_DONE: begin
                n_state = snt_pkg::S_IDLE;
            end
            default: n_state = snt_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != snt_pkg::S_IDLE);
        unique case (r_state)
            snt_pkg::S_IDLE: begin
                o_cmd.load = i_start;
            end
            snt_pkg::S_CHECK: begin
                o_cmd.div_start = i_status.cand_ok;
            end
            snt_pkg::S_TEST_A: begin
                // Divisor found: strip it once, else try the next candidate
                o_cmd.take_quot = i_status.rem_zero;
                o_cmd.next_cand = !i_status.rem_zero;
            end
            snt_pkg::S_START_B: begin
                o_cmd.div_start = 1'b1;
            end
            snt_pkg::S_TEST_B: begin
                // Repeated factor or a fourth prime disqualifies
                if (i_status.rem_zero || i_status.primes_full) begin
                    o_cmd.fail = 1'b1;
                end else begin
                    o_cmd.count_prime = 1'b1;
                    o_cmd.next_cand   = 1'b1;
                end
            end
            snt_pkg::S_DONE: begin
                o_cmd.emit = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/sphenic_number_test_unit.sv
// Top level of the sphenic number test: controller plus datapath.
//
// Channel   Direction  Ports                  Handshake
// request   in         start, i_value         taken when start && !busy
// result    out        o_valid, o_is_sphenic  one-cycle strobe, no back-pressure
//
// Each trial candidate d takes one division on the shared restoring divider; a
// divisor costs a second division. Candidates run while d*d <= cofactor, so at
// most about sqrt(value) candidates are tried. The result strobe is registered
// and rises in the cycle after the done state; busy is low then.
// Reset is synchronous and active low; no clearing pass is needed.
module sphenic_number_test_unit #(
    parameter int VALUE_WIDTH = snt_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   busy,
    output logic                   o_valid,
    output logic                   o_is_sphenic
);
    snt_pkg::t_cmd    cmd;
    snt_pkg::t_status status;

    snt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    snt_dpath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_value      (i_value),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_valid      (o_valid),
        .o_is_sphenic (o_is_sphenic)
    );

`ifndef SYNTH
    // An accepted request keeps the unit busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but unit not busy");

    // Results are only strobed once the unit has gone idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // One result per request: the strobe is never repeated back to back
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe repeated");

    // A result is produced only after the unit was working
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(busy))
        else $error("result strobe without work");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the sphenic number test unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW = snt_pkg::DEFAULT_VALUE_WIDTH;
    localparam int unsigned VALUE_MAX = (1 << VW) - 1;
    localparam int unsigned SMALL_PRIMES [12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};

    // One outstanding classification: the value sent and the verdict it must get
    typedef struct {
        logic [VW-1:0] value;
        logic          sphenic;
    } t_verdict;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic [VW-1:0] i_value = '0;
    logic          busy;
    logic          o_valid;
    logic          o_is_sphenic;

    logic [VW-1:0] request_queue [$];
    t_verdict      verdict_queue [$];
    logic          req_taken = 1'b0;
    int unsigned   idle_pct = 0;
    int unsigned   mismatches = 0;
    int unsigned   requests_sent = 0;
    int unsigned   sphenic_seen = 0;

    sphenic_number_test_unit #(.VALUE_WIDTH(VW)) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_value      (i_value),
        .busy         (busy),
        .o_valid      (o_valid),
        .o_is_sphenic (o_is_sphenic)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Factor by trial division; a repeated factor or a fourth prime rules the value out
    function automatic logic predict_sphenic(logic [VW-1:0] v);
        int unsigned rest;
        int unsigned d;
        int unsigned nprimes;
        rest = v;
        nprimes = 0;
        if (rest < snt_pkg::FIRST_CANDIDATE)
            return 1'b0;
        for (d = snt_pkg::FIRST_CANDIDATE; d * d <= rest; d++) begin
            if (rest % d == 0) begin
                rest = rest / d;
                if (rest % d == 0)
                    return 1'b0;
                nprimes++;
                if (nprimes > snt_pkg::PRIME_TARGET)
                    return 1'b0;
            end
        end
        if (rest > 1)
            nprimes++;
        return nprimes == snt_pkg::PRIME_TARGET;
    endfunction

    function automatic bit is_prime(int unsigned n);
        if (n < 2)
            return 0;
        for (int unsigned d = 2; d * d <= n; d++) begin
            if (n % d == 0)
                return 0;
        end
        return 1;
    endfunction

    // Random request: mostly built sphenic values and near misses, some small and full-range noise
    function automatic logic [VW-1:0] random_request();
        int unsigned kind;
        int unsigned p;
        int unsigned q;
        int unsigned r;
        int unsigned prod;
        int unsigned f;
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
            // p*q*r with distinct primes, r possibly large
            do begin
                p = SMALL_PRIMES[$urandom_range(0, 11)];
                q = SMALL_PRIMES[$urandom_range(0, 11)];
            end while (p == q);
            do begin
                r = $urandom_range(2, VALUE_MAX / (p * q));
            end while (!is_prime(r) || r == p || r == q);
            return VW'(p * q * r);
        end else if (kind < 55) begin
            // product of two to five small primes, repeats allowed, so a squared factor can occur
            prod = 1;
            for (int i = 0; i < $urandom_range(2, 5); i++) begin
                f = SMALL_PRIMES[$urandom_range(0, 11)];
                if (prod * f <= VALUE_MAX)
                    prod = prod * f;
            end
            return VW'(prod);
        end else if (kind < 85) begin
            return VW'($urandom_range(0, 4095));
        end
        return VW'($urandom_range(0, VALUE_MAX));
    endfunction

    // Driver: presents queued requests at the falling edge, holds each until taken
    always @(negedge i_clk) begin : drv
        logic          drive;
        logic [VW-1:0] val;
        drive = start;
        val = i_value;
        if (!i_rst_n) begin
            drive = 1'b0;
        end else begin
            if (start && req_taken)
                drive = 1'b0;
            if (!drive && request_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                drive = 1'b1;
                val = request_queue.pop_front();
            end
        end
        start <= drive;
        i_value <= val;
    end

    // Monitor: record accepted requests, check each result strobe against the oldest verdict
    always @(posedge i_clk) begin : mon
        t_verdict v;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= start && !busy;
            if (start && !busy) begin
                v.value = i_value;
                v.sphenic = predict_sphenic(i_value);
                verdict_queue.push_back(v);
                requests_sent++;
                if (v.sphenic)
                    sphenic_seen++;
            end
            if (o_valid) begin
                if (verdict_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result %0b with no request outstanding", o_is_sphenic);
                end else begin
                    v = verdict_queue.pop_front();
                    if (o_is_sphenic !== v.sphenic) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: value %0d expected is_sphenic=%0b got %0b",
                                     v.value, v.sphenic, o_is_sphenic);
                    end
                end
            end
        end
    end

    // Stimulus: reset, directed corners, then three random phases with different idle rates
    initial begin : stim
        logic [VW-1:0] directed [$];
        directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd8, 16'd30, 16'd60, 16'd97,
                     16'd231, 16'd294, 16'd1001, 16'd1024, 16'd30030, 16'd32768,
                     16'd65535, 16'd65534, 16'd65530, 16'd65521, 16'hAAAA, 16'h5555,
                     16'd62054};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        idle_pct = 13;
        foreach (directed[i])
            request_queue.push_back(directed[i]);
        repeat (26)
            request_queue.push_back(random_request());
        while (request_queue.size() > 0)
            @(posedge i_clk);

        idle_pct = 80;
        repeat (26)
            request_queue.push_back(random_request());
        while (request_queue.size() > 0)
            @(posedge i_clk);

        idle_pct = 0;
        repeat (26)
            request_queue.push_back(random_request());

        // drain: everything taken, every verdict returned, then a short tail
        while (request_queue.size() > 0 || start || verdict_queue.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Classified %0d values, %0d of them sphenic.", requests_sent, sphenic_seen);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #100_000_000;
        $display("Timeout with %0d results outstanding", verdict_queue.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/snt_pkg.sv
rtl/snt_div.sv
rtl/snt_dpath.sv
rtl/snt_ctrl.sv
rtl/sphenic_number_test_unit.sv
tb/testbench.sv
